// ===== rtl/core/mrsrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsrb_pkg
// Shared types, constants and helpers for the segmented ring buffer core.
// ----------------------------------------------------------------------------
package mrsrb_pkg;

  localparam int unsigned MAX_LINES    = 256;
  localparam int unsigned LINE_BYTES   = 8;
  localparam int unsigned MAX_SEGMENTS = 4;
  localparam int unsigned MAX_READERS  = 4;

  localparam int unsigned PTR_W     = $clog2(MAX_LINES);
  localparam int unsigned SEG_W     = $clog2(MAX_SEGMENTS);
  localparam int unsigned RDR_W     = $clog2(MAX_READERS);
  localparam int unsigned RIDX_W    = SEG_W + RDR_W;
  localparam int unsigned ADDR_W    = SEG_W + PTR_W;
  localparam int unsigned DATA_W    = 8 * LINE_BYTES;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned LINES_W   = 9;
  localparam int unsigned SEGCNT_W  = 3;
  localparam int unsigned RDRCNT_W  = 3;
  localparam int unsigned LINE_DEPTH = MAX_SEGMENTS * MAX_LINES;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LINES_W-1:0]  CFG_LINES_RST = LINES_W'(MAX_LINES);
  localparam logic [LEN_W-1:0]    CFG_BYTES_RST = LEN_W'(LINE_BYTES);
  localparam logic [SEGCNT_W-1:0] CFG_SEGS_RST  = SEGCNT_W'(MAX_SEGMENTS);
  localparam logic [RDRCNT_W-1:0] CFG_RDRS_RST  = RDRCNT_W'(MAX_READERS);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ARG  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_LINES = 3'd0,
    REG_BYTES = 3'd1,
    REG_SEGS  = 3'd2,
    REG_RDRS  = 3'd3,
    REG_OVWR  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MEM,
    ST_LOAD,
    ST_RESP
  } state_e;

  // Saturated configuration in use
  typedef struct packed {
    logic [LINES_W-1:0]  lines;
    logic [LEN_W-1:0]    lbytes;
    logic [SEGCNT_W-1:0] segs;
    logic [RDRCNT_W-1:0] rdrs;
    logic                ovwr;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [SEG_W-1:0]  seg;
    logic [RDR_W-1:0]  rdr;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  count;
    logic [DATA_W-1:0] data;
  } res_t;

  typedef struct packed {
    logic              wp_we;
    logic              rp_we;
    logic [SEG_W-1:0]  seg;
    logic [RIDX_W-1:0] ridx;
    logic [PTR_W-1:0]  nxt;
  } ptr_ctl_t;

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
  } ptr_sts_t;

  typedef struct packed {
    logic                  we;
    logic [LINE_BYTES-1:0] be;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     wdata;
  } mem_req_t;

  function automatic logic [LINE_BYTES-1:0] byte_en(logic [LEN_W-1:0] n);
    logic [LINE_BYTES-1:0] e;
    e = '0;
    for (int b = 0; b < LINE_BYTES; b++) begin
      e[b] = (LEN_W'(b) < n);
    end
    return e;
  endfunction

  function automatic logic [DATA_W-1:0] byte_mask(logic [LEN_W-1:0] n);
    logic [DATA_W-1:0]     m;
    logic [LINE_BYTES-1:0] e;
    e = byte_en(n);
    for (int b = 0; b < LINE_BYTES; b++) begin
      m[b*8 +: 8] = {8{e[b]}};
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/mrsrb_line_ram.sv =====
// ----------------------------------------------------------------------------
// mrsrb_line_ram
// Line store: single port, byte write enables, registered read data.
// ----------------------------------------------------------------------------
module mrsrb_line_ram
  import mrsrb_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [LINE_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int b = 0; b < LINE_BYTES; b++) begin
        if (req_i.be[b]) begin
          mem_q[req_i.addr][b*8 +: 8] <= req_i.wdata[b*8 +: 8];
        end
      end
    end
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mrsrb_ptr_file.sv =====
// ----------------------------------------------------------------------------
// mrsrb_ptr_file
// Write index per segment and read index per segment and reader.
// ----------------------------------------------------------------------------
module mrsrb_ptr_file
  import mrsrb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ptr_ctl_t ctl_i,
  output ptr_sts_t sts_o
);

  logic [PTR_W-1:0] wp_q [MAX_SEGMENTS];
  logic [PTR_W-1:0] rp_q [MAX_SEGMENTS*MAX_READERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '{default: '0};
      rp_q <= '{default: '0};
    end else begin
      if (ctl_i.wp_we) begin
        wp_q[ctl_i.seg] <= ctl_i.nxt;
      end
      if (ctl_i.rp_we) begin
        rp_q[ctl_i.ridx] <= ctl_i.nxt;
      end
    end
  end

  assign sts_o.wp = wp_q[ctl_i.seg];
  assign sts_o.rp = rp_q[ctl_i.ridx];

endmodule

// ===== rtl/core/mrsrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrsrb_ctrl
// Sequencer: argument checks, reader scan on the shared comparator,
// line access and result assembly; clears the line store after reset.
// ----------------------------------------------------------------------------
module mrsrb_ctrl
  import mrsrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output ptr_ctl_t          ptr_ctl_o,
  input  ptr_sts_t          ptr_sts_i,
  output mem_req_t          mem_req_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  state_e            state_q, state_d;
  item_t             item_q;
  res_t              res_q, res_d;
  logic [RDR_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic               seg_bad, rdr_bad, len_big, len_zero;
  logic [LEN_W-1:0]   rd_n;
  logic [PTR_W-1:0]   cur_ptr, nxt_ptr, cmp_b;
  logic [LINES_W-1:0] lines_m1;
  logic               cmp_eq, last_rdr;

  assign seg_bad  = SEGCNT_W'(item_q.seg) >= cfg_i.segs;
  assign rdr_bad  = RDRCNT_W'(item_q.rdr) >= cfg_i.rdrs;
  assign len_big  = item_q.len > cfg_i.lbytes;
  assign len_zero = item_q.len == '0;
  assign rd_n     = (item_q.len < cfg_i.lbytes) ? item_q.len : cfg_i.lbytes;

  // shared index advance with wrap
  assign cur_ptr  = (item_q.op == OP_READ) ? ptr_sts_i.rp : ptr_sts_i.wp;
  assign lines_m1 = cfg_i.lines - LINES_W'(1);
  assign nxt_ptr  = (LINES_W'(cur_ptr) >= lines_m1) ? '0 : cur_ptr + PTR_W'(1);

  // shared comparator: reader index against next write index or write index
  assign cmp_b    = (item_q.op == OP_WRITE) ? nxt_ptr : ptr_sts_i.wp;
  assign cmp_eq   = ptr_sts_i.rp == cmp_b;
  assign last_rdr = RDRCNT_W'(idx_q) == (cfg_i.rdrs - RDRCNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (item_q.op == OP_WRITE) begin
          if (seg_bad || len_big || len_zero) state_d = ST_RESP;
          else if (cfg_i.ovwr)                state_d = ST_MEM;
          else                                state_d = ST_SCAN;
        end else begin
          if (seg_bad || rdr_bad || len_zero || cmp_eq) state_d = ST_RESP;
          else                                          state_d = ST_MEM;
        end
      end
      ST_SCAN: begin
        if (cmp_eq)        state_d = ST_RESP;
        else if (last_rdr) state_d = ST_MEM;
      end
      ST_MEM:  state_d = (item_q.op == OP_WRITE) ? ST_RESP : ST_LOAD;
      ST_LOAD: state_d = ST_RESP;
      ST_RESP: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d           = res_q;
    idx_d           = idx_q;
    clr_d           = clr_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.be    = '0;
    mem_req_o.addr  = {item_q.seg, cur_ptr};
    mem_req_o.wdata = item_q.wdata;
    ptr_ctl_o.wp_we = 1'b0;
    ptr_ctl_o.rp_we = 1'b0;
    ptr_ctl_o.seg   = item_q.seg;
    ptr_ctl_o.ridx  = (state_q == ST_SCAN) ? {item_q.seg, idx_q} : {item_q.seg, item_q.rdr};
    ptr_ctl_o.nxt   = nxt_ptr;
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.be    = '1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = '0;
        clr_d           = clr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
      end
      ST_CHECK: begin
        res_d.status = STATUS_OK;
        res_d.count  = '0;
        res_d.data   = '0;
        if ((item_q.op == OP_WRITE && (seg_bad || len_big)) ||
            (item_q.op == OP_READ && (seg_bad || rdr_bad))) begin
          res_d.status = STATUS_ARG;
        end
      end
      ST_SCAN: begin
        if (cmp_eq) res_d.status = STATUS_FULL;
        else        idx_d = idx_q + RDR_W'(1);
      end
      ST_MEM: begin
        if (item_q.op == OP_WRITE) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.be    = byte_en(item_q.len);
          ptr_ctl_o.wp_we = 1'b1;
          res_d.count     = item_q.len;
        end else begin
          ptr_ctl_o.rp_we = 1'b1;
        end
      end
      ST_LOAD: begin
        res_d.count = rd_n;
        res_d.data  = mem_rdata_i & byte_mask(rd_n);
      end
      ST_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/multi_reader_segmented_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// multi_reader_segmented_ring_buffer_core
// Segmented line rings with one writer and per-reader read indices.
// ----------------------------------------------------------------------------
// Steps from input transaction to output register: argument errors, zero
// lengths and empty reads go from CHECK to RESP, reads through MEM and LOAD,
// writes with overwrite through MEM, writes without through SCAN (one reader
// a cycle) and MEM. One transaction at a time; the output register takes the
// result so the next transaction can enter while it waits.
// Reset clears indices, then sweeps 1024 lines with s_axis_tready low.
module multi_reader_segmented_ring_buffer_core
  import mrsrb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // op [0], segment [2:1], reader [4:3]
  input  logic [4:0]         s_axis_tuser,
  // length [3:0], write_data [67:4], zero pad [71:68]
  input  logic [71:0]        s_axis_tdata,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // status [1:0]
  output logic [1:0]         m_axis_tuser,
  // byte_count [3:0], read_data [67:4], zero pad [71:68]
  output logic [71:0]        m_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [LINES_W-1:0]  lines_q;
  logic [LEN_W-1:0]    bytes_q;
  logic [SEGCNT_W-1:0] segs_q;
  logic [RDRCNT_W-1:0] rdrs_q;
  logic                ovwr_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  cfg_t              cfg;
  item_t             item;
  res_t              res;
  logic              res_valid, res_ready;
  ptr_ctl_t          ptr_ctl;
  ptr_sts_t          ptr_sts;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  logic        m_valid_q;
  logic [71:0] m_data_q;
  logic [1:0]  m_user_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= CFG_LINES_RST;
      bytes_q <= CFG_BYTES_RST;
      segs_q  <= CFG_SEGS_RST;
      rdrs_q  <= CFG_RDRS_RST;
      ovwr_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LINES: lines_q <= pwdata[LINES_W-1:0];
        REG_BYTES: bytes_q <= pwdata[LEN_W-1:0];
        REG_SEGS:  segs_q  <= pwdata[SEGCNT_W-1:0];
        REG_RDRS:  rdrs_q  <= pwdata[RDRCNT_W-1:0];
        REG_OVWR:  ovwr_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINES: prdata = PDATA_W'(lines_q);
      REG_BYTES: prdata = PDATA_W'(bytes_q);
      REG_SEGS:  prdata = PDATA_W'(segs_q);
      REG_RDRS:  prdata = PDATA_W'(rdrs_q);
      REG_OVWR:  prdata = PDATA_W'(ovwr_q);
      default:   prdata = '0;
    endcase
  end

  // values in use, saturated to the legal range
  always_comb begin
    cfg.lines  = (lines_q == '0) ? LINES_W'(1) :
                 (lines_q > CFG_LINES_RST) ? CFG_LINES_RST : lines_q;
    cfg.lbytes = (bytes_q == '0) ? LEN_W'(1) :
                 (bytes_q > CFG_BYTES_RST) ? CFG_BYTES_RST : bytes_q;
    cfg.segs   = (segs_q == '0) ? SEGCNT_W'(1) :
                 (segs_q > CFG_SEGS_RST) ? CFG_SEGS_RST : segs_q;
    cfg.rdrs   = (rdrs_q == '0) ? RDRCNT_W'(1) :
                 (rdrs_q > CFG_RDRS_RST) ? CFG_RDRS_RST : rdrs_q;
    cfg.ovwr   = ovwr_q;
  end

  assign item.op    = op_e'(s_axis_tuser[0]);
  assign item.seg   = s_axis_tuser[2:1];
  assign item.rdr   = s_axis_tuser[4:3];
  assign item.len   = s_axis_tdata[3:0];
  assign item.wdata = s_axis_tdata[67:4];

  mrsrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ptr_ctl_o   (ptr_ctl),
    .ptr_sts_i   (ptr_sts),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  mrsrb_ptr_file u_ptr_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ptr_ctl),
    .sts_o  (ptr_sts)
  );

  mrsrb_line_ram u_line_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {4'b0, res.data, res.count};
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/core/mrsrb_checker.sv =====
// ----------------------------------------------------------------------------
// mrsrb_checker
// Port-level checks on the ring buffer core, bound to the top level.
// ----------------------------------------------------------------------------
module mrsrb_checker
  import mrsrb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: no back-to-back input transactions
  a_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in consecutive cycles");

  // refused or bad transactions carry no bytes
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)
    else $error("non-ok result carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'(LINE_BYTES) &&
      m_axis_tuser != 2'd3)
    else $error("result count or status out of range");

endmodule

bind multi_reader_segmented_ring_buffer_core mrsrb_checker u_checker (.*);
